>>> rtl/erpd_pkg.sv
// Package for the escape-coded run-length palette decoder.
// Holds widths, register indexes, the run request type and the fixed palette.
// Has no dependencies.
package erpd_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam int ARGB_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int RUN_LEN_W       = 16;
    localparam int POS_W           = 24;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 24;

    localparam logic [BYTE_W-1:0]      ESCAPE_BYTE = 8'hFF;
    localparam logic [POS_W-1:0]       POS_MAX     = 24'hFF_FFFF;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_OFFSET  = 8'd1;

    // One decoded run, handed from the token decoder to the output pipeline.
    typedef struct packed {
        logic                  emit;
        logic [BYTE_W-1:0]     idx;
        logic [RUN_LEN_W-1:0]  len;
    } run_t;

    localparam logic [ARGB_W-1:0] PALETTE [PALETTE_ENTRIES] = '{
        32'hff000000, 32'hffab0303, 32'hff03ab03, 32'hffabab03,
        32'hff0303ab, 32'hffab03ab, 32'hff0357ab, 32'hffababab,
        32'hff575757, 32'hffff5757, 32'hff57ff57, 32'hffffff57,
        32'hff5757ff, 32'hffff57ff, 32'hff57ffff, 32'hffffffff,
        32'hff000000, 32'hff171717, 32'hff232323, 32'hff2f2f2f,
        32'hff3b3b3b, 32'hff474747, 32'hff535353, 32'hff636363,
        32'hff737373, 32'hff838383, 32'hff939393, 32'hffa3a3a3,
        32'hffb7b7b7, 32'hffcbcbcb, 32'hffe3e3e3, 32'hffffffff,
        32'hffff0303, 32'hffff0343, 32'hffff037f, 32'hffff03bf,
        32'hffff03ff, 32'hffbf03ff, 32'hff7f03ff, 32'hff4303ff,
        32'hff0303ff, 32'hff0343ff, 32'hff037fff, 32'hff03bfff,
        32'hff03ffff, 32'hff03ffbf, 32'hff03ff7f, 32'hff03ff43,
        32'hff03ff03, 32'hff43ff03, 32'hff7fff03, 32'hffbfff03,
        32'hffffff03, 32'hffffbf03, 32'hffff7f03, 32'hffff4303,
        32'hffff7f7f, 32'hffff7f9f, 32'hffff7fbf, 32'hffff7fdf,
        32'hffff7fff, 32'hffdf7fff, 32'hffbf7fff, 32'hff9f7fff,
        32'hff7f7fff, 32'hff7f9fff, 32'hff7fbfff, 32'hff7fdfff,
        32'hff7fffff, 32'hff7fffdf, 32'hff7fffbf, 32'hff7fff9f,
        32'hff7fff7f, 32'hff9fff7f, 32'hffbfff7f, 32'hffdfff7f,
        32'hffffff7f, 32'hffffdf7f, 32'hffffbf7f, 32'hffff9f7f,
        32'hffffb7b7, 32'hffffb7c7, 32'hffffb7db, 32'hffffb7eb,
        32'hffffb7ff, 32'hffebb7ff, 32'hffdbb7ff, 32'hffc7b7ff,
        32'hffb7b7ff, 32'hffb7c7ff, 32'hffb7dbff, 32'hffb7ebff,
        32'hffb7ffff, 32'hffb7ffeb, 32'hffb7ffdb, 32'hffb7ffc7,
        32'hffb7ffb7, 32'hffc7ffb7, 32'hffdbffb7, 32'hffebffb7,
        32'hffffffb7, 32'hffffebb7, 32'hffffdbb7, 32'hffffc7b7,
        32'hff730303, 32'hff73031f, 32'hff73033b, 32'hff730357,
        32'hff730373, 32'hff570373, 32'hff3b0373, 32'hff1f0373,
        32'hff030373, 32'hff031f73, 32'hff033b73, 32'hff035773,
        32'hff037373, 32'hff037357, 32'hff03733b, 32'hff03731f,
        32'hff037303, 32'hff1f7303, 32'hff3b7303, 32'hff577303,
        32'hff737303, 32'hff735703, 32'hff733b03, 32'hff731f03,
        32'hff733b3b, 32'hff733b47, 32'hff733b57, 32'hff733b63,
        32'hff733b73, 32'hff633b73, 32'hff573b73, 32'hff473b73,
        32'hff3b3b73, 32'hff3b4773, 32'hff3b5773, 32'hff3b6373,
        32'hff3b7373, 32'hff3b7363, 32'hff3b7357, 32'hff3b7347,
        32'hff3b733b, 32'hff47733b, 32'hff57733b, 32'hff63733b,
        32'hff73733b, 32'hff73633b, 32'hff73573b, 32'hff73473b,
        32'hff735353, 32'hff73535b, 32'hff735363, 32'hff73536b,
        32'hff735373, 32'hff6b5373, 32'hff635373, 32'hff5b5373,
        32'hff535373, 32'hff535b73, 32'hff536373, 32'hff536b73,
        32'hff537373, 32'hff53736b, 32'hff537363, 32'hff53735b,
        32'hff537353, 32'hff5b7353, 32'hff637353, 32'hff6b7353,
        32'hff737353, 32'hff736b53, 32'hff736353, 32'hff735b53,
        32'hff430303, 32'hff430313, 32'hff430323, 32'hff430333,
        32'hff430343, 32'hff330343, 32'hff230343, 32'hff130343,
        32'hff030343, 32'hff031343, 32'hff032343, 32'hff033343,
        32'hff034343, 32'hff034333, 32'hff034323, 32'hff034313,
        32'hff034303, 32'hff134303, 32'hff234303, 32'hff334303,
        32'hff434303, 32'hff433303, 32'hff432303, 32'hff431303,
        32'hff432323, 32'hff43232b, 32'hff432333, 32'hff43233b,
        32'hff432343, 32'hff3b2343, 32'hff332343, 32'hff2b2343,
        32'hff232343, 32'hff232b43, 32'hff233343, 32'hff233b43,
        32'hff234343, 32'hff23433b, 32'hff234333, 32'hff23432b,
        32'hff234323, 32'hff2b4323, 32'hff334323, 32'hff3b4323,
        32'hff434323, 32'hff433b23, 32'hff433323, 32'hff432b23,
        32'hff432f2f, 32'hff432f33, 32'hff432f37, 32'hff432f3f,
        32'hff432f43, 32'hff3f2f43, 32'hff372f43, 32'hff332f43,
        32'hff2f2f43, 32'hff2f3343, 32'hff2f3743, 32'hff2f3f43,
        32'hff2f4343, 32'hff2f433f, 32'hff2f4337, 32'hff2f4333,
        32'hff2f432f, 32'hff33432f, 32'hff37432f, 32'hff3f432f,
        32'hff43432f, 32'hff433f2f, 32'hff43372f, 32'hff43332f,
        32'hff000000, 32'hff000000, 32'hff000000, 32'hff000000,
        32'hff000000, 32'hff000000, 32'hff000000, 32'hff000000
    };

endpackage

>>> rtl/erpd_ifs.sv
// Channel interfaces of the escape-coded run-length palette decoder:
// coded byte input, decoded run output and configuration writes.
// Depends on erpd_pkg.
interface erpd_in_if
    import erpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] coded_byte;

    modport source (output valid, output coded_byte, input ready);
    modport sink   (input valid, input coded_byte, output ready);
endinterface

interface erpd_out_if
    import erpd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    color_index;
    logic [ARGB_W-1:0]    pixel_argb;
    logic [RUN_LEN_W-1:0] run_length;

    modport source (output valid, output color_index, output pixel_argb,
                    output run_length, input ready);
    modport sink   (input valid, input color_index, input pixel_argb,
                    input run_length, output ready);
endinterface

interface erpd_cfg_if
    import erpd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/erpd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Has no dependencies.
module erpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/erpd_token_dec.sv
// Token decoder: tracks the escape token phase and the stream byte position,
// and turns each accepted byte into at most one run request.
// Depends on erpd_pkg.
module erpd_token_dec
    import erpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] coded_byte,
    input  logic [POS_W-1:0]  stream_length,
    output run_t              run
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_HIGH  = 2'd3;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [BYTE_W-1:0] run_value_reg;
    logic [BYTE_W-1:0] run_value_next;
    logic [BYTE_W-1:0] count_low_reg;
    logic [BYTE_W-1:0] count_low_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_inc;
    logic              at_end;
    logic [RUN_LEN_W-1:0] count;

    // A new token may start only while position + 1 is below the length.
    assign at_end  = ({1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1}) >= {1'b0, stream_length};
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign count   = {coded_byte, count_low_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        run_value_next = run_value_reg;
        count_low_next = count_low_reg;
        pos_next       = pos_reg;
        run.emit       = 1'b0;
        run.idx        = coded_byte;
        run.len        = {{(RUN_LEN_W-1){1'b0}}, 1'b1};
        if (accept)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (!at_end)
                    begin
                        pos_next = pos_inc;
                        if (coded_byte == ESCAPE_BYTE)
                        begin
                            phase_next = PH_VALUE;
                        end
                        else
                        begin
                            run.emit = 1'b1;
                        end
                    end
                end
                PH_VALUE:
                begin
                    pos_next       = pos_inc;
                    run_value_next = coded_byte;
                    phase_next     = PH_LOW;
                end
                PH_LOW:
                begin
                    pos_next       = pos_inc;
                    count_low_next = coded_byte;
                    phase_next     = PH_HIGH;
                end
                PH_HIGH:
                begin
                    pos_next   = pos_inc;
                    phase_next = PH_START;
                    run.idx    = run_value_reg;
                    run.len    = count;
                    run.emit   = (count != '0);
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            run_value_reg <= '0;
            count_low_reg <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_value_reg <= run_value_next;
            count_low_reg <= count_low_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

>>> rtl/erpd_out_stage.sv
// Output pipeline: a lookup stage that waits on the palette read, then the
// output register that drives the run channel.
// Depends on erpd_pkg and erpd_ifs.
module erpd_out_stage
    import erpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  run_t              run,
    input  logic [ARGB_W-1:0] pal_rdata,
    output logic              advance,
    erpd_out_if.source        runs
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [BYTE_W-1:0]    s1_idx_reg;
    logic [RUN_LEN_W-1:0] s1_len_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_W-1:0]    out_idx_reg;
    logic [ARGB_W-1:0]    out_argb_reg;
    logic [RUN_LEN_W-1:0] out_len_reg;
    logic                 load_out;

    // The lookup stage moves on when the output register is free or drains.
    assign load_out = s1_valid_reg && (!out_valid_reg || runs.ready);
    assign advance  = !s1_valid_reg || load_out;

    always_comb
    begin
        s1_valid_next  = advance ? run.emit : s1_valid_reg;
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !runs.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && run.emit)
        begin
            s1_idx_reg <= run.idx;
            s1_len_reg <= run.len;
        end
        if (load_out)
        begin
            out_idx_reg  <= s1_idx_reg;
            out_len_reg  <= s1_len_reg;
            out_argb_reg <= (s1_idx_reg == '0) ? '0 : pal_rdata;
        end
    end

    assign runs.valid       = out_valid_reg;
    assign runs.color_index = out_idx_reg;
    assign runs.pixel_argb  = out_argb_reg;
    assign runs.run_length  = out_len_reg;

endmodule

>>> rtl/escape_rle_palette_decoder.sv
// Top level of the escape-coded run-length palette decoder.
// Depends on erpd_pkg, erpd_ifs, erpd_ram, erpd_token_dec and erpd_out_stage.
//
// Usage:
//   coded  - input channel, one byte of the coded stream per transfer.
//   runs   - output channel, one decoded run per transfer: raw index, ARGB
//            colour (zero for index 0) and run length.
//   cfg    - configuration writes; index 0 is stream_length, index 1 is
//            color_offset. Writes to other indexes are dropped. Always ready.
// After reset the palette RAM is loaded from the constant table, one entry a
// cycle, and coded.ready stays low until all 256 entries are in; cfg writes
// are taken during that sweep. Reset also clears both registers, the token
// state and the byte position.
// Throughput is one byte per cycle once the sweep is done and while the
// receiver keeps up. A completed run enters the lookup stage together with
// its palette RAM read and then moves on to the output register once that is
// free. The lookup stage and the output register together hold two runs, so
// input keeps flowing while one finished run waits. When the receiver stalls,
// the runs payload holds and coded.ready falls only once both stages are full.
module escape_rle_palette_decoder
    import erpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    erpd_in_if.sink    coded,
    erpd_out_if.source runs,
    erpd_cfg_if.sink   cfg
);

    logic [PAL_ADDR_W:0]   fill_cnt_reg;
    logic [PAL_ADDR_W:0]   fill_cnt_next;
    logic                  fill_done;
    logic [POS_W-1:0]      stream_length_reg;
    logic [BYTE_W-1:0]     color_offset_reg;
    logic                  cfg_write;
    logic                  accept;
    logic                  advance;
    run_t                  run;
    logic [PAL_ADDR_W-1:0] pal_raddr;
    logic [ARGB_W-1:0]     pal_rdata;

    // The top bit of the fill counter marks that all palette entries are loaded.
    assign fill_done     = fill_cnt_reg[PAL_ADDR_W];
    assign fill_cnt_next = fill_done ? fill_cnt_reg : fill_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // Configuration registers take effect on the next input byte.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= '0;
            color_offset_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                CFG_STREAM_LENGTH: stream_length_reg <= cfg.data[POS_W-1:0];
                CFG_COLOR_OFFSET:  color_offset_reg  <= cfg.data[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign coded.ready = fill_done && advance;
    assign accept      = coded.valid && coded.ready;

    erpd_token_dec u_token_dec (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .coded_byte    (coded.coded_byte),
        .stream_length (stream_length_reg),
        .run           (run)
    );

    // The palette index wraps modulo the table size.
    assign pal_raddr = run.idx + color_offset_reg;

    erpd_ram #(
        .WIDTH (ARGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk   (clk),
        .we    (!fill_done),
        .waddr (fill_cnt_reg[PAL_ADDR_W-1:0]),
        .wdata (PALETTE[fill_cnt_reg[PAL_ADDR_W-1:0]]),
        .re    (run.emit),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    erpd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .pal_rdata (pal_rdata),
        .advance   (advance),
        .runs      (runs)
    );

`ifndef ASSERT_OFF
    a_no_input_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> fill_done)
        else $error("input byte taken while the palette was still loading");

    a_read_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        run.emit |-> (fill_done && advance))
        else $error("palette read issued outside an accepted byte");

    a_zero_index_black: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && (runs.color_index == '0)) |-> (runs.pixel_argb == '0))
        else $error("index zero run carries a nonzero colour");

    a_nonzero_length: assert property (@(posedge clk) disable iff (!rst_n)
        runs.valid |-> (runs.run_length != '0))
        else $error("run of length zero presented");
`endif

endmodule

>>> sim/erpd_run_checker.sv
// Checker for the escape-coded run-length palette decoder: watches the byte,
// run and register-write channels, predicts every run and compares it.
// Depends on erpd_pkg and the channel interfaces in erpd_ifs.
module erpd_run_checker
    import erpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    erpd_in_if               coded,
    erpd_out_if              runs,
    erpd_cfg_if              cfg,
    output int               mismatches,
    output int               pending,
    output logic [POS_W-1:0] coded_position
);

    typedef enum logic [1:0] {
        AWAIT_START,
        AWAIT_VALUE,
        AWAIT_COUNT_LO,
        AWAIT_COUNT_HI
    } token_phase_e;

    typedef struct packed {
        logic [BYTE_W-1:0]    color_index;
        logic [ARGB_W-1:0]    pixel_argb;
        logic [RUN_LEN_W-1:0] run_length;
    } run_rec_t;

    logic [POS_W-1:0]  stream_length_q;
    logic [POS_W-1:0]  position_q;
    logic [BYTE_W-1:0] offset_q;
    logic [BYTE_W-1:0] value_q;
    logic [BYTE_W-1:0] count_lo_q;
    token_phase_e      phase_q;
    run_rec_t          expected_runs[$];
    int                runs_seen;

    function automatic logic [ARGB_W-1:0] color_of(input logic [BYTE_W-1:0] idx);
        logic [PAL_ADDR_W-1:0] slot;
        slot = idx + offset_q;
        return (idx == '0) ? '0 : PALETTE[slot];
    endfunction

    // Advances the token state by one coded byte; returns 1 when a run is due.
    function automatic logic decode_byte(input logic [BYTE_W-1:0] b, output run_rec_t run);
        logic [RUN_LEN_W-1:0] count;
        run = '0;
        // A new token may only start while at least two bytes of the stream remain.
        if (phase_q == AWAIT_START && {1'b0, position_q} + 1'b1 >= {1'b0, stream_length_q})
            return 1'b0;
        if (position_q != POS_MAX)
            position_q = position_q + 1'b1;
        case (phase_q)
            AWAIT_START:
            begin
                if (b == ESCAPE_BYTE)
                begin
                    phase_q = AWAIT_VALUE;
                    return 1'b0;
                end
                run = '{b, color_of(b), RUN_LEN_W'(1)};
                return 1'b1;
            end
            AWAIT_VALUE:
            begin
                value_q = b;
                phase_q = AWAIT_COUNT_LO;
            end
            AWAIT_COUNT_LO:
            begin
                count_lo_q = b;
                phase_q = AWAIT_COUNT_HI;
            end
            default:
            begin
                phase_q = AWAIT_START;
                count = {b, count_lo_q};
                if (count != '0)
                begin
                    run = '{value_q, color_of(value_q), count};
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        run_rec_t fresh;
        run_rec_t want;
        if (!rst_n)
        begin
            stream_length_q = '0;
            offset_q        = '0;
            value_q         = '0;
            count_lo_q      = '0;
            position_q      = '0;
            phase_q         = AWAIT_START;
            expected_runs.delete();
            runs_seen       = 0;
            mismatches      = 0;
            pending        <= 0;
            coded_position <= '0;
        end
        else
        begin
            // Writes and byte transfers never share a cycle, so their order here is free.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_STREAM_LENGTH: stream_length_q = cfg.data;
                    CFG_COLOR_OFFSET:  offset_q = cfg.data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (coded.valid && coded.ready)
            begin
                if (decode_byte(coded.coded_byte, fresh))
                    expected_runs = {expected_runs, fresh};
            end
            if (runs.valid && runs.ready)
            begin
                runs_seen++;
                if (expected_runs.size() == 0)
                    report_mismatch($sformatf("run %0d (index %0h, length %0d) not expected",
                                              runs_seen, runs.color_index, runs.run_length));
                else
                begin
                    want = expected_runs.pop_front();
                    if (runs.color_index !== want.color_index)
                        report_mismatch($sformatf("run %0d color_index %0h, expected %0h",
                                                  runs_seen, runs.color_index, want.color_index));
                    if (runs.pixel_argb !== want.pixel_argb)
                        report_mismatch($sformatf("run %0d pixel_argb %0h, expected %0h",
                                                  runs_seen, runs.pixel_argb, want.pixel_argb));
                    if (runs.run_length !== want.run_length)
                        report_mismatch($sformatf("run %0d run_length %0d, expected %0d",
                                                  runs_seen, runs.run_length, want.run_length));
                end
            end
            pending        <= expected_runs.size();
            coded_position <= position_q;
        end
    end

endmodule

>>> sim/escape_rle_palette_decoder_test.sv
// Top of the decoder testbench: clock, reset, byte and register-write stimulus,
// run receiver with random stalls, and the final verdict.
// Depends on erpd_pkg, erpd_ifs, erpd_run_checker and the decoder RTL.
module escape_rle_palette_decoder_test;
    import erpd_pkg::*;

    localparam int MAX_WAIT      = 13;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PRESSURE_TURN = 2;

    // The largest stream length never stops a token from starting in this run.
    localparam logic [CFG_DATA_W-1:0]  OPEN_LENGTH        = POS_MAX;
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = CFG_COLOR_OFFSET + 1'b1;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    bit               in_burst;
    bit               out_burst;
    bit               hold_runs;
    int               mismatches;
    int               pending;
    logic [POS_W-1:0] stream_pos;

    erpd_in_if  coded_ch ();
    erpd_out_if runs_ch ();
    erpd_cfg_if cfg_ch ();

    escape_rle_palette_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coded (coded_ch),
        .runs  (runs_ch),
        .cfg   (cfg_ch)
    );

    // The checker predicts every run from the transfers it sees and reports
    // the byte position it has reached, which the stimulus uses to place the
    // end of the stream.
    erpd_run_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .coded          (coded_ch),
        .runs           (runs_ch),
        .cfg            (cfg_ch),
        .mismatches     (mismatches),
        .pending        (pending),
        .coded_position (stream_pos)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offers one coded byte after a random gap and returns at the edge of its
    // transfer. Valid is left high so that a following byte with no gap goes
    // out back to back; it is only lowered at the start of a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            coded_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coded_ch.valid      <= 1'b1;
        coded_ch.coded_byte <= value;
        do @(posedge clk); while (!coded_ch.ready);
    endtask

    task automatic send_token(input logic [BYTE_W-1:0] value, input logic [RUN_LEN_W-1:0] count);
        send_byte(ESCAPE_BYTE);
        send_byte(value);
        send_byte(count[7:0]);
        send_byte(count[15:8]);
    endtask

    // One register write; valid stays high until the caller lowers it, so
    // that back-to-back writes need no gap.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // The upper bits of the data word are random; only the low byte counts.
    task automatic set_offset(input logic [BYTE_W-1:0] offset);
        write_reg(CFG_COLOR_OFFSET, {16'($urandom), offset});
    endtask

    task automatic write_unused_reg();
        write_reg(CFG_INDEX_W'($urandom_range(int'(FIRST_UNUSED_INDEX), 255)),
                  CFG_DATA_W'($urandom));
    endtask

    // Stops offering bytes and waits until every predicted run has left.
    // Escape and count bytes cause no run, so a few more cycles let the last
    // of them pass through before any register is touched.
    task automatic settle();
        coded_ch.valid <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Run receiver. Each run waits a random number of cycles before ready
    // rises. Once, on request, the hold-off is long enough for both run
    // stages of the decoder to fill so that it stops taking coded bytes.
    initial
    begin
        int stall;
        runs_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold_runs)
            begin
                hold_runs = 1'b0;
                stall += HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                runs_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            runs_ch.ready <= 1'b1;
            do @(posedge clk); while (!runs_ch.valid);
        end
    end

    initial
    begin
        int                   turn;
        int                   n;
        int                   pick;
        bit                   pressure;
        logic [BYTE_W-1:0]    offset;
        logic [RUN_LEN_W-1:0] count;
        logic [POS_W-1:0]     target;

        coded_ch.valid      <= 1'b0;
        coded_ch.coded_byte <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        in_burst  = 1'b0;
        out_burst = 1'b0;
        hold_runs = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The stream length is zero out of reset, so this byte is dropped.
        // It is only taken once the palette sweep after reset is done.
        send_byte(8'h05);
        settle();

        // A length of one still leaves no room for a token to start.
        write_reg(CFG_STREAM_LENGTH, CFG_DATA_W'(1));
        cfg_ch.valid <= 1'b0;
        send_byte(8'h11);
        settle();

        // Open-ended stream: the literal extremes, index zero mapping to a
        // clear pixel, the longest run, a token of count zero that gives no
        // run, and a count that lives only in the high byte.
        write_reg(CFG_STREAM_LENGTH, OPEN_LENGTH);
        set_offset(8'h00);
        cfg_ch.valid <= 1'b0;
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(8'h01);
        send_token(8'hFF, 16'hFFFF);
        send_token(8'h07, 16'h0000);
        send_token(8'h80, 16'h0100);

        // Registers rewritten while a token is half done: the new offset
        // applies to the pending run at once, and the stream end is pulled in
        // to the current position, which must not cut the open token short.
        // A write to an index past the two registers has no effect.
        send_byte(ESCAPE_BYTE);
        send_byte(8'h09);
        settle();
        set_offset(8'hFF);
        write_reg(CFG_STREAM_LENGTH, stream_pos);
        write_unused_reg();
        cfg_ch.valid <= 1'b0;
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h44);
        settle();

        // Exactly one more byte may start a token before the stream end.
        write_reg(CFG_STREAM_LENGTH, stream_pos + 2'd2);
        cfg_ch.valid <= 1'b0;
        send_byte(8'h21);
        send_byte(8'h22);
        settle();

        // Random phases. Each one picks a register setting and an idling
        // style, then sends mostly literals and well-formed tokens with random
        // contents, plus a few arbitrary bytes. Progress is counted by the
        // byte position, so bytes dropped past a stream end do not count.
        turn   = 0;
        target = stream_pos + POS_W'(RANDOM_ITEMS);
        while (stream_pos < target)
        begin
            pressure = (turn == PRESSURE_TURN);
            case ($urandom_range(0, 3))
                0:       offset = 8'h00;
                1:       offset = 8'hFF;
                default: offset = 8'($urandom);
            endcase
            set_offset(offset);
            if (!pressure && $urandom_range(0, 5) == 0)
            begin
                // A short stream that ends somewhere inside this phase, or
                // one that is already over.
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_STREAM_LENGTH, CFG_DATA_W'($urandom_range(0, 1)));
                else
                    write_reg(CFG_STREAM_LENGTH, stream_pos + POS_W'($urandom_range(1, 40)));
            end
            else
                write_reg(CFG_STREAM_LENGTH, OPEN_LENGTH);
            if ($urandom_range(0, 3) == 0)
                write_unused_reg();
            cfg_ch.valid <= 1'b0;

            // In the pressure phase the sender never pauses while the
            // receiver holds off, so the decoder has to stall its input.
            in_burst  = pressure || $urandom_range(0, 3) == 0;
            out_burst = !pressure && $urandom_range(0, 3) == 0;
            if (pressure)
                hold_runs = 1'b1;

            n = pressure ? 80 : $urandom_range(15, 50);
            repeat (n)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    send_byte(BYTE_W'($urandom_range(0, 254)));
                else if (pick < 18)
                begin
                    case ($urandom_range(0, 9))
                        0:          count = '0;
                        1:          count = '1;
                        2, 3, 4, 5: count = RUN_LEN_W'($urandom_range(1, 8));
                        default:    count = RUN_LEN_W'($urandom);
                    endcase
                    send_token(BYTE_W'($urandom), count);
                end
                else
                    send_byte(BYTE_W'($urandom));
            end

            // Sometimes a token is left open across the next phase's writes.
            if ($urandom_range(0, 2) == 0)
            begin
                send_byte(ESCAPE_BYTE);
                repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom));
            end
            settle();
            turn++;
        end

        if (mismatches == 0 && pending == 0)
            $display("escape_rle_palette_decoder test passed");
        else
            $display("escape_rle_palette_decoder test failed");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial
    begin
        #5000000;
        $display("escape_rle_palette_decoder test failed");
        $finish;
    end

endmodule
